[hdl/tzps_pkg.sv]
// ----------------------------------------------------------------------------
// tzps_pkg
// Shared types, widths and helpers for the triangle z-plane slicer.
// ----------------------------------------------------------------------------
package tzps_pkg;

  localparam int COORD_WIDTH = 32;
  // edge differences need one more bit than a coordinate
  localparam int QW          = COORD_WIDTH + 1;
  localparam int PW          = 2 * QW;
  localparam int LANES       = 4;
  localparam int ADDR_WIDTH  = 3;

  // register index taken from paddr[2]
  localparam logic REG_CUT_HEIGHT = 1'b0;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vertex_t;

  // one divider lane: partial remainder, low dividend bits, quotient so far
  typedef struct packed {
    logic [QW-1:0] rem;
    logic [QW-1:0] nlo;
    logic [QW-1:0] q;
    logic [QW-1:0] d;
    logic          neg;
    coord_t        base;
  } lane_t;

  typedef struct packed {
    logic                  hit;
    coord_t                zc;
    lane_t [LANES-1:0]     lane;
  } dstage_t;

  function automatic logic signed [QW-1:0] sext_q(input coord_t v);
    sext_q = {v[COORD_WIDTH-1], v};
  endfunction

  function automatic logic [QW-1:0] mag_q(input logic signed [QW-1:0] v);
    mag_q = v[QW-1] ? (~v + 1'b1) : v;
  endfunction

  // one restoring step, one quotient bit
  function automatic lane_t div_step(input lane_t l);
    lane_t         r;
    logic [QW:0]   t;
    logic [QW:0]   diff;
    logic          ge;
    r    = l;
    t    = {l.rem, l.nlo[QW-1]};
    diff = t - {1'b0, l.d};
    ge   = (t >= {1'b0, l.d});
    r.rem = ge ? diff[QW-1:0] : t[QW-1:0];
    r.nlo = {l.nlo[QW-2:0], 1'b0};
    r.q   = {l.q[QW-2:0], ge};
    return r;
  endfunction

endpackage

[hdl/triangle_z_plane_slice.sv]
// ----------------------------------------------------------------------------
// triangle_z_plane_slice
// Slices one triangle per item with the plane z = cut_height.
// ----------------------------------------------------------------------------
// Takes one triangle per cycle while in_stall is low and returns one result
// item per triangle, in order. The pipeline is four set-up stages (capture,
// vertex split, edge differences, multiply), 33 stages of a one-bit-per-stage
// restoring divider for each of the four x/y crossing coordinates, and the
// output register. z of both crossing points is cut_height itself. A stall on
// the output while an item is valid freezes the whole pipeline and is passed
// back as in_stall. No hit gives zero coordinates.
module triangle_z_plane_slice import tzps_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [COORD_WIDTH-1:0] in_vertex_a_x,
  input  logic [COORD_WIDTH-1:0] in_vertex_a_y,
  input  logic [COORD_WIDTH-1:0] in_vertex_a_z,
  input  logic [COORD_WIDTH-1:0] in_vertex_b_x,
  input  logic [COORD_WIDTH-1:0] in_vertex_b_y,
  input  logic [COORD_WIDTH-1:0] in_vertex_b_z,
  input  logic [COORD_WIDTH-1:0] in_vertex_c_x,
  input  logic [COORD_WIDTH-1:0] in_vertex_c_y,
  input  logic [COORD_WIDTH-1:0] in_vertex_c_z,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_slice_hit,
  output logic [COORD_WIDTH-1:0] out_first_x,
  output logic [COORD_WIDTH-1:0] out_first_y,
  output logic [COORD_WIDTH-1:0] out_first_z,
  output logic [COORD_WIDTH-1:0] out_second_x,
  output logic [COORD_WIDTH-1:0] out_second_y,
  output logic [COORD_WIDTH-1:0] out_second_z,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_WIDTH-1:0]  paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  coord_t cut_height_r;

  logic    adv;
  logic    s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r;
  vertex_t s1_v_r [3];
  coord_t  s1_zc_r;

  vertex_t s2_a_nxt [2], s2_b_nxt [2];
  logic    s2_hit_nxt;
  vertex_t s2_a_r [2], s2_b_r [2];
  logic    s2_hit_r;
  coord_t  s2_zc_r;

  logic [QW-1:0] s3_n_nxt [LANES], s3_m_nxt [LANES], s3_d_nxt [LANES];
  logic          s3_neg_nxt [LANES];
  coord_t        s3_base_nxt [LANES];
  logic [QW-1:0] s3_n_r [LANES], s3_m_r [LANES], s3_d_r [LANES];
  logic          s3_neg_r [LANES];
  coord_t        s3_base_r [LANES];
  logic          s3_hit_r;
  coord_t        s3_zc_r;

  logic [PW-1:0] s4_p_r [LANES];
  logic [QW-1:0] s4_d_r [LANES];
  logic          s4_neg_r [LANES];
  coord_t        s4_base_r [LANES];
  logic          s4_hit_r;
  coord_t        s4_zc_r;

  dstage_t dv_in  [QW];
  dstage_t dv_r   [QW];
  logic    dv_valid_r [QW];

  coord_t res_nxt [LANES];
  logic   out_valid_r, out_hit_r;
  coord_t out_fx_r, out_fy_r, out_sx_r, out_sy_r, out_z_r;

  // ---------------- configuration ----------------
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CUT_HEIGHT) ? cut_height_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cut_height_r <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_CUT_HEIGHT) begin
      cut_height_r <= pwdata[COORD_WIDTH-1:0];
    end
  end

  // whole pipeline moves unless the output item is held
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  // ---------------- stage 2: split vertices ----------------
  always_comb begin
    logic [2:0] below;
    for (int i = 0; i < 3; i++) begin
      below[i] = (s1_v_r[i].z <= s1_zc_r);
    end
    s2_hit_nxt  = 1'b1;
    s2_a_nxt[0] = s1_v_r[0];
    s2_b_nxt[0] = s1_v_r[1];
    s2_a_nxt[1] = s1_v_r[0];
    s2_b_nxt[1] = s1_v_r[2];
    case (below)
      3'b001: begin
        s2_a_nxt[0] = s1_v_r[1]; s2_b_nxt[0] = s1_v_r[0];
        s2_a_nxt[1] = s1_v_r[2]; s2_b_nxt[1] = s1_v_r[0];
      end
      3'b010: begin
        s2_a_nxt[0] = s1_v_r[0]; s2_b_nxt[0] = s1_v_r[1];
        s2_a_nxt[1] = s1_v_r[2]; s2_b_nxt[1] = s1_v_r[1];
      end
      3'b100: begin
        s2_a_nxt[0] = s1_v_r[0]; s2_b_nxt[0] = s1_v_r[2];
        s2_a_nxt[1] = s1_v_r[1]; s2_b_nxt[1] = s1_v_r[2];
      end
      3'b011: begin
        s2_a_nxt[0] = s1_v_r[2]; s2_b_nxt[0] = s1_v_r[0];
        s2_a_nxt[1] = s1_v_r[2]; s2_b_nxt[1] = s1_v_r[1];
      end
      3'b101: begin
        s2_a_nxt[0] = s1_v_r[1]; s2_b_nxt[0] = s1_v_r[0];
        s2_a_nxt[1] = s1_v_r[1]; s2_b_nxt[1] = s1_v_r[2];
      end
      3'b110: begin
        s2_a_nxt[0] = s1_v_r[0]; s2_b_nxt[0] = s1_v_r[1];
        s2_a_nxt[1] = s1_v_r[0]; s2_b_nxt[1] = s1_v_r[2];
      end
      default: begin
        // all above or all at/below: no crossing
        s2_hit_nxt = 1'b0;
      end
    endcase
  end

  // ---------------- stage 3: edge differences ----------------
  always_comb begin
    logic signed [QW-1:0] n, d, m;
    coord_t               ak, bk;
    for (int l = 0; l < LANES; l++) begin
      // lanes: edge l/2, coordinate x for even, y for odd
      ak = (l % 2 == 0) ? s2_a_r[l/2].x : s2_a_r[l/2].y;
      bk = (l % 2 == 0) ? s2_b_r[l/2].x : s2_b_r[l/2].y;
      n  = sext_q(s2_zc_r) - sext_q(s2_a_r[l/2].z);
      d  = sext_q(s2_b_r[l/2].z) - sext_q(s2_a_r[l/2].z);
      m  = sext_q(bk) - sext_q(ak);
      s3_n_nxt[l]    = mag_q(n);
      s3_d_nxt[l]    = mag_q(d);
      s3_m_nxt[l]    = mag_q(m);
      s3_neg_nxt[l]  = n[QW-1] ^ d[QW-1] ^ m[QW-1];
      s3_base_nxt[l] = ak;
    end
  end

  // ---------------- divider input ----------------
  always_comb begin
    dv_in[0].hit = s4_hit_r;
    dv_in[0].zc  = s4_zc_r;
    for (int l = 0; l < LANES; l++) begin
      // quotient fits in QW bits, so the high half is already below d
      dv_in[0].lane[l].rem  = s4_p_r[l][PW-1:QW];
      dv_in[0].lane[l].nlo  = s4_p_r[l][QW-1:0];
      dv_in[0].lane[l].q    = '0;
      dv_in[0].lane[l].d    = s4_d_r[l];
      dv_in[0].lane[l].neg  = s4_neg_r[l];
      dv_in[0].lane[l].base = s4_base_r[l];
    end
    for (int j = 1; j < QW; j++) begin
      dv_in[j] = dv_r[j-1];
    end
  end

  // ---------------- final sign and offset ----------------
  always_comb begin
    logic [QW-1:0] qs;
    logic [QW-1:0] sum;
    for (int l = 0; l < LANES; l++) begin
      qs  = dv_r[QW-1].lane[l].neg ? (~dv_r[QW-1].lane[l].q + 1'b1) : dv_r[QW-1].lane[l].q;
      sum = sext_q(dv_r[QW-1].lane[l].base) + qs;
      res_nxt[l] = dv_r[QW-1].hit ? sum[COORD_WIDTH-1:0] : '0;
    end
  end

  // ---------------- valid bits ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int j = 0; j < QW; j++) begin
        dv_valid_r[j] <= 1'b0;
      end
    end else if (adv) begin
      s1_valid_r    <= in_valid;
      s2_valid_r    <= s1_valid_r;
      s3_valid_r    <= s2_valid_r;
      s4_valid_r    <= s3_valid_r;
      dv_valid_r[0] <= s4_valid_r;
      for (int j = 1; j < QW; j++) begin
        dv_valid_r[j] <= dv_valid_r[j-1];
      end
      out_valid_r <= dv_valid_r[QW-1];
    end
  end

  // ---------------- payload ----------------
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_v_r[0] <= '{x: in_vertex_a_x, y: in_vertex_a_y, z: in_vertex_a_z};
      s1_v_r[1] <= '{x: in_vertex_b_x, y: in_vertex_b_y, z: in_vertex_b_z};
      s1_v_r[2] <= '{x: in_vertex_c_x, y: in_vertex_c_y, z: in_vertex_c_z};
      s1_zc_r   <= cut_height_r;

      s2_a_r   <= s2_a_nxt;
      s2_b_r   <= s2_b_nxt;
      s2_hit_r <= s2_hit_nxt;
      s2_zc_r  <= s1_zc_r;

      s3_n_r    <= s3_n_nxt;
      s3_m_r    <= s3_m_nxt;
      s3_d_r    <= s3_d_nxt;
      s3_neg_r  <= s3_neg_nxt;
      s3_base_r <= s3_base_nxt;
      s3_hit_r  <= s2_hit_r;
      s3_zc_r   <= s2_zc_r;

      for (int l = 0; l < LANES; l++) begin
        s4_p_r[l] <= s3_n_r[l] * s3_m_r[l];
      end
      s4_d_r    <= s3_d_r;
      s4_neg_r  <= s3_neg_r;
      s4_base_r <= s3_base_r;
      s4_hit_r  <= s3_hit_r;
      s4_zc_r   <= s3_zc_r;

      for (int j = 0; j < QW; j++) begin
        dv_r[j].hit <= dv_in[j].hit;
        dv_r[j].zc  <= dv_in[j].zc;
        for (int l = 0; l < LANES; l++) begin
          dv_r[j].lane[l] <= div_step(dv_in[j].lane[l]);
        end
      end

      out_hit_r <= dv_r[QW-1].hit;
      out_fx_r  <= res_nxt[0];
      out_fy_r  <= res_nxt[1];
      out_sx_r  <= res_nxt[2];
      out_sy_r  <= res_nxt[3];
      out_z_r   <= dv_r[QW-1].hit ? dv_r[QW-1].zc : '0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_slice_hit = out_hit_r;
  assign out_first_x   = out_fx_r;
  assign out_first_y   = out_fy_r;
  assign out_first_z   = out_z_r;
  assign out_second_x  = out_sx_r;
  assign out_second_y  = out_sy_r;
  assign out_second_z  = out_z_r;

  // ---------------- assertions ----------------
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_slice_hit |-> out_first_x == '0 && out_first_y == '0 &&
      out_second_x == '0 && out_second_y == '0 && out_first_z == '0)
    else $error("no-hit item carries nonzero coordinates");

  a_hit_z: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_slice_hit |-> out_first_z == out_second_z)
    else $error("crossing points differ in z");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> $stable(s4_valid_r) && $stable(dv_valid_r[0]))
    else $error("pipeline moved during stall");

endmodule

[dv/triangle_z_plane_slice_test.sv]
// ----------------------------------------------------------------------------
// triangle_z_plane_slice_test
// Self-checking bench for the triangle z-plane slicer: a short stimulus table
// (extremes, no-hit cases, both vertex splits) then random triangles, with
// every result compared to an exact integer predictor at several cut heights.
// ----------------------------------------------------------------------------
module triangle_z_plane_slice_test import tzps_pkg::*;;

  typedef struct {
    coord_t v[9];
  } tri_t;

  typedef struct {
    logic   hit;
    coord_t c[6];
  } slice_t;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  coord_t in_v[9];
  logic out_slice_hit;
  logic [COORD_WIDTH-1:0] out_c[6];
  logic psel, penable, pwrite;
  logic [ADDR_WIDTH-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  coord_t cut_height;
  slice_t expected_slices[$];
  int errors, hits, misses, sent;
  bit hold_recv;
  bit quiet_phase;

  triangle_z_plane_slice u_dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_vertex_a_x(in_v[0]), .in_vertex_a_y(in_v[1]), .in_vertex_a_z(in_v[2]),
    .in_vertex_b_x(in_v[3]), .in_vertex_b_y(in_v[4]), .in_vertex_b_z(in_v[5]),
    .in_vertex_c_x(in_v[6]), .in_vertex_c_y(in_v[7]), .in_vertex_c_z(in_v[8]),
    .out_valid(out_valid), .out_stall(out_stall), .out_slice_hit(out_slice_hit),
    .out_first_x(out_c[0]), .out_first_y(out_c[1]), .out_first_z(out_c[2]),
    .out_second_x(out_c[3]), .out_second_y(out_c[4]), .out_second_z(out_c[5]),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #30000000;
    $display("Verification failed");
    $finish;
  end

  // exact crossing coordinate on the edge from above vertex a to below vertex b
  function automatic coord_t edge_cross(coord_t ak, coord_t az, coord_t bk, coord_t bz,
                                        coord_t zc);
    longint n, d, m;
    logic signed [127:0] p, q;
    n = longint'(zc) - longint'(az);
    d = longint'(bz) - longint'(az);
    m = longint'(bk) - longint'(ak);
    p = 128'(n) * 128'(m);
    q = p / 128'(d);  // truncates toward zero
    return coord_t'(longint'(ak) + longint'(q));
  endfunction

  function automatic slice_t slice_triangle(tri_t t, coord_t zc);
    slice_t r;
    coord_t mn, mx;
    int below[3], above[3];
    int nb, na, a1, b1, a2, b2;
    r.hit = 0;
    foreach (r.c[k]) r.c[k] = '0;
    nb = 0; na = 0;
    mn = t.v[2]; mx = t.v[2];
    for (int i = 1; i < 3; i++) begin
      if (t.v[3*i+2] < mn) mn = t.v[3*i+2];
      if (t.v[3*i+2] > mx) mx = t.v[3*i+2];
    end
    if (zc < mn || zc > mx) return r;
    for (int i = 0; i < 3; i++) begin
      if (t.v[3*i+2] <= zc) below[nb++] = i;
      else above[na++] = i;
    end
    if (nb == 3) return r;
    if (nb == 2) begin
      a1 = above[0]; b1 = below[0]; a2 = above[0]; b2 = below[1];
    end else begin
      a1 = above[0]; b1 = below[0]; a2 = above[1]; b2 = below[0];
    end
    r.hit = 1;
    for (int k = 0; k < 3; k++) begin
      r.c[k] = edge_cross(t.v[3*a1+k], t.v[3*a1+2], t.v[3*b1+k], t.v[3*b1+2], zc);
      r.c[3+k] = edge_cross(t.v[3*a2+k], t.v[3*a2+2], t.v[3*b2+k], t.v[3*b2+2], zc);
    end
    return r;
  endfunction

  task automatic write_cut(coord_t value);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {REG_CUT_HEIGHT, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    cut_height = value;
  endtask

  task automatic wait_drained();
    while (expected_slices.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic send_triangle(tri_t t);
    in_valid <= 1;
    foreach (t.v[k]) in_v[k] <= t.v[k];
    expected_slices = {expected_slices, slice_triangle(t, cut_height)};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    if (!quiet_phase && $urandom_range(99) < 36) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  function automatic coord_t rand_coord(coord_t zc);
    case ($urandom_range(5))
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(1) ? 32'h7fffffff : 32'h80000000);
      default: return coord_t'(longint'(zc) + $signed($urandom_range(2000)) - 1000);
    endcase
  endfunction

  function automatic tri_t rand_triangle(coord_t zc);
    tri_t t;
    foreach (t.v[k]) t.v[k] = ($urandom_range(3) == 0) ? coord_t'($urandom)
                                                        : rand_coord(zc);
    return t;
  endfunction

  // receiver: random stall, with a long hold on request
  initial begin
    out_stall = 1;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_recv) begin
        out_stall <= 1;
        repeat (120) @(posedge clk);
        hold_recv = 0;
      end
      out_stall <= quiet_phase ? 1'b0 : ($urandom_range(99) < 36);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      slice_t e;
      if (expected_slices.size() == 0) begin
        $display("%0t: result with nothing expected", $time);
        errors++;
      end else begin
        e = expected_slices.pop_front();
        if (e.hit) hits++; else misses++;
        if (out_slice_hit !== e.hit) begin
          $display("%0t: slice_hit expected %0d actual %0d", $time, e.hit, out_slice_hit);
          errors++;
        end
        for (int k = 0; k < 6; k++)
          if (out_c[k] !== e.c[k]) begin
            $display("%0t: coord %0d expected %0d actual %0d", $time, k, e.c[k],
                     $signed(out_c[k]));
            errors++;
          end
      end
    end
  end

  localparam coord_t MAXC = 32'sh7fffffff;
  localparam coord_t MINC = 32'sh80000000;

  // stimulus table: triangle and, where obvious, the expected hit flag (-1 = predict)
  typedef struct {
    coord_t v[9];
    int hit;
  } row_t;

  row_t dir_rows[$];
  coord_t cuts[6];

  initial begin
    tri_t t;
    slice_t pred;
    int n_rand;
    in_valid = 0; foreach (in_v[k]) in_v[k] = '0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    rst_n = 0; cut_height = 0; errors = 0; sent = 0; hold_recv = 0; quiet_phase = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    dir_rows = '{
      '{'{0,0,0, 0,0,0, 0,0,0}, 0},                       // all at plane: no hit
      '{'{0,0,65536, 0,0,65536, 0,0,65536}, 0},           // all above
      '{'{0,0,-1, 1,1,-2, 2,2,-3}, 0},                    // all below
      '{'{0,0,-65536, 65536,0,65536, 0,65536,-65536}, -1}, // two below one above
      '{'{0,0,65536, 65536,0,-65536, 0,65536,65536}, -1},  // one below two above
      '{'{MAXC,MAXC,MAXC, MINC,MINC,MINC, 0,0,0}, -1},
      '{'{MINC,MAXC,MINC, MAXC,MINC,MAXC, MAXC,MAXC,MAXC}, -1},
      '{'{MAXC,MINC,MINC, MINC,MAXC,MAXC, MINC,MINC,MINC}, -1},
      '{'{-5,7,-1, 9,-3,1, 3,3,0}, -1},
      '{'{100,-100,MAXC, -100,100,MINC, 0,0,1}, -1},
      '{'{MINC,MINC,MINC, MINC,MINC,MINC, MINC,MINC,MINC}, 0},
      '{'{MAXC,MAXC,MAXC, MAXC,MAXC,MAXC, MAXC,MAXC,MAXC}, 0}
    };
    foreach (dir_rows[r]) begin
      foreach (t.v[k]) t.v[k] = dir_rows[r].v[k];
      pred = slice_triangle(t, cut_height);
      if (dir_rows[r].hit == 0 && pred.hit !== 1'b0) begin
        $display("%0t: table row %0d expected no hit", $time, r);
        errors++;
      end
      send_triangle(t);
    end
    in_valid <= 0;
    wait_drained();

    // back-pressure: hold the receiver while offering items
    hold_recv = 1;
    for (int i = 0; i < 80; i++) send_triangle(rand_triangle(cut_height));
    in_valid <= 0;
    wait_drained();

    cuts = '{MAXC, MINC, 32'sh00010000, -32'sh00018000, coord_t'($urandom), 0};
    foreach (cuts[p]) begin
      write_cut(cuts[p]);
      n_rand = (p == 5) ? 300 : 160;
      quiet_phase = (p == 2);
      for (int i = 0; i < n_rand; i++) send_triangle(rand_triangle(cut_height));
      in_valid <= 0;
      quiet_phase = 0;
      wait_drained();
    end

    $display("sent %0d triangles over %0d cut heights", sent, 7);
    $display("results checked: %0d hits, %0d misses", hits, misses);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

[filelist.f]
hdl/tzps_pkg.sv
hdl/triangle_z_plane_slice.sv
dv/triangle_z_plane_slice_test.sv
